// ===== rtl/psm_pkg.sv =====
package psm_pkg;

  // Channel slots inside a packed color word
  localparam int unsigned CH_RED   = 2;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned NUM_CH   = 3;

  typedef logic [NUM_CH-1:0][7:0] psm_rgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_image;
  } psm_in_t;

  typedef struct packed {
    logic [7:0] median_red;
    logic [7:0] median_green;
    logic [7:0] median_blue;
    logic       overflowed;
  } psm_out_t;

  // What one cell shows its right-hand neighbor
  typedef struct packed {
    logic [NUM_CH-1:0] take;  // this cell moves to the right on insert
    psm_rgb_t          val;
  } psm_link_t;

endpackage

// ===== rtl/psm_cell.sv =====
module psm_cell (
  input  logic                clk,
  input  logic                insert,
  input  logic                occ,
  input  psm_pkg::psm_rgb_t   sample,
  input  psm_pkg::psm_link_t  left,
  output psm_pkg::psm_link_t  right,
  output psm_pkg::psm_rgb_t   val
);

  psm_pkg::psm_rgb_t          val_next;
  logic [psm_pkg::NUM_CH-1:0] take;

  // an empty cell or one holding a larger value gives way
  always_comb begin
    for (int c = 0; c < psm_pkg::NUM_CH; c++) begin
      take[c] = !occ || (sample[c] < val[c]);
    end
  end

  always_comb begin
    val_next = val;
    for (int c = 0; c < psm_pkg::NUM_CH; c++) begin
      if (left.take[c]) begin
        val_next[c] = left.val[c];
      end else if (take[c]) begin
        val_next[c] = sample[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      val <= val_next;
    end
  end

  assign right.take = take;
  assign right.val  = val;

endmodule

// ===== rtl/pixel_stack_median_color_unit.sv =====
// Per-pixel color median over an image stack.
// Input channel (pixel_valid / pixel_stall / pixel): one beat per image of the
// stack for a single pixel position, carrying red, green, blue and last_image.
// Output channel (median_valid / median_stall / median): one beat per stack,
// holding each channel's value at sorted index count/2 (upper median for an
// even count) and an overflowed flag.
// Each channel keeps its own ascending insertion chain of MAX_IMAGES cells;
// a beat is inserted in the cycle it is accepted, so while pixel_stall is low
// the chain takes one beat per clock. Beats past MAX_IMAGES are dropped and
// set the overflow flag. An accepted last_image beat sets pending; once the
// output register is free, the median is loaded and median_valid is set.
// pixel_stall is high for one cycle after each last_image beat while the
// median is loaded. The output register holds the result, so the next stack
// streams in while a result waits; if median_stall keeps the register full
// when the next median is due, pixel_stall stays high until it is taken.
// Reset (rst, synchronous): empties the chain, clears the overflow flag and
// drops any pending result. Cell contents are not reset; occupancy comes
// from the sample count.
module pixel_stack_median_color_unit #(
  parameter int unsigned MAX_IMAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  psm_pkg::psm_in_t   pixel,
  output logic               median_valid,
  input  logic               median_stall,
  output psm_pkg::psm_out_t  median
);

  localparam int unsigned CW = $clog2(MAX_IMAGES + 1);
  localparam int unsigned IW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;

  logic [CW-1:0]      count;
  logic               overflow_seen;
  logic               pending;     // last beat taken, median not yet loaded

  logic               in_beat;
  logic               out_free;
  logic               full;
  logic               insert;
  logic [IW-1:0]      med_idx;
  psm_pkg::psm_rgb_t  sample;
  psm_pkg::psm_rgb_t  med_val;

  psm_pkg::psm_link_t link [MAX_IMAGES+1];
  psm_pkg::psm_rgb_t  cell_val [MAX_IMAGES];

  assign pixel_stall = pending;
  assign in_beat     = pixel_valid && !pixel_stall;
  assign out_free    = !median_valid || !median_stall;
  assign full        = (count == CW'(MAX_IMAGES));
  assign insert      = in_beat && !full;

  assign sample[psm_pkg::CH_RED]   = pixel.red;
  assign sample[psm_pkg::CH_GREEN] = pixel.green;
  assign sample[psm_pkg::CH_BLUE]  = pixel.blue;

  // head of the chain never pushes anything in
  assign link[0] = '0;

  for (genvar i = 0; i < MAX_IMAGES; i++) begin : g_cell
    logic occ;
    assign occ = (count > CW'(i));
    psm_cell u_cell (
      .clk    (clk),
      .insert (insert),
      .occ    (occ),
      .sample (sample),
      .left   (link[i]),
      .right  (link[i+1]),
      .val    (cell_val[i])
    );
  end

  // tail link only matters inside the last cell
  logic unused_tail;
  assign unused_tail = ^link[MAX_IMAGES];

  // count is at least one when the median is loaded
  assign med_idx = IW'(count >> 1);
  assign med_val = cell_val[med_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      pending       <= 1'b0;
      median_valid  <= 1'b0;
    end else begin
      if (in_beat) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
        if (pixel.last_image) begin
          pending <= 1'b1;
        end
      end
      // input is stalled while pending, so no beat competes with this
      if (pending && out_free) begin
        median_valid  <= 1'b1;
        count         <= '0;
        overflow_seen <= 1'b0;
        pending       <= 1'b0;
      end else if (median_valid && !median_stall) begin
        median_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pending && out_free) begin
      median.median_red   <= med_val[psm_pkg::CH_RED];
      median.median_green <= med_val[psm_pkg::CH_GREEN];
      median.median_blue  <= med_val[psm_pkg::CH_BLUE];
      median.overflowed   <= overflow_seen;
    end
  end

endmodule

// ===== rtl/psm_checker.sv =====
module psm_checker (
  input logic               clk,
  input logic               rst,
  input logic               pixel_valid,
  input logic               pixel_stall,
  input psm_pkg::psm_in_t   pixel,
  input logic               median_valid,
  input logic               median_stall,
  input psm_pkg::psm_out_t  median
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    median_valid && median_stall |=> median_valid && $stable(median))
    else $error("median beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !median_valid)
    else $error("median valid right after reset");

  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && pixel.last_image |=> pixel_stall)
    else $error("no load cycle after last image");

  a_mid_flow: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && !pixel.last_image |=> !pixel_stall)
    else $error("stall inside a stack");

  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(median_valid) |-> $past(pixel_stall))
    else $error("median appeared without a finished stack");

endmodule

bind pixel_stack_median_color_unit psm_checker u_psm_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .pixel        (pixel),
  .median_valid (median_valid),
  .median_stall (median_stall),
  .median       (median)
);
